// File: rtl/load_cell_average_tare_weigh_unit_defines.svh
// Assertion macros shared by the load cell tare and weigh block.
`ifndef LOAD_CELL_AVERAGE_TARE_WEIGH_UNIT_DEFINES_SVH
`define LOAD_CELL_AVERAGE_TARE_WEIGH_UNIT_DEFINES_SVH

// Checked on every rising clock edge outside of reset.
`define LCTW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define LCTW_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/lctw_pkg.sv
package lctw_pkg;

  // Width of the shared divider operands.
  localparam int DIV_W = 34;

  localparam int MAX_WINDOW_DEFAULT = 64;

  localparam int SAMPLE_W   = 24;
  localparam int OUT_W      = 22;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 72;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNTS_PER_KG = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY_KG   = 2'd2;

  localparam logic [6:0]  WINDOW_LENGTH_RESET = 7'd10;
  localparam logic [23:0] COUNTS_PER_KG_RESET = 24'd29400;
  localparam logic [7:0]  CAPACITY_KG_RESET   = 8'd13;

  localparam logic [SAMPLE_W-1:0] FULL_SCALE_POS = 24'h7FFFFF;
  localparam logic [SAMPLE_W-1:0] FULL_SCALE_NEG = 24'h800000;

  localparam logic [DIV_W-1:0] OUT_POS_MAG = DIV_W'(2097151);
  localparam logic [DIV_W-1:0] OUT_NEG_MAG = DIV_W'(2097152);
  localparam logic [OUT_W-1:0] OUT_MAX_CODE = 22'h1FFFFF;
  localparam logic [OUT_W-1:0] OUT_MIN_CODE = 22'h200000;

  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_NO_SAMPLE  = 2'd1,
    STATUS_FULL_SCALE = 2'd2
  } status_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

// File: rtl/lctw_div.sv
module lctw_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [lctw_pkg::DIV_W-1:0] dividend,
  input  logic [lctw_pkg::DIV_W-1:0] divisor,
  output logic [lctw_pkg::DIV_W-1:0] quotient,
  output lctw_pkg::div_status_t      status
);
  import lctw_pkg::*;

  localparam int CW = $clog2(DIV_W + 1);

  logic [DIV_W-1:0] quo;
  logic [DIV_W-1:0] rem;
  logic [DIV_W-1:0] dsr;
  logic [CW-1:0]    cnt;
  logic             busy;
  logic             done;
  logic [DIV_W:0]   rem_sh;
  logic [DIV_W:0]   trial;
  logic             fits;

  // Restoring division, one quotient bit per cycle, MSB first.
  always_comb begin
    rem_sh = {rem, quo[DIV_W-1]};
    trial  = rem_sh - {1'b0, dsr};
    fits   = !trial[DIV_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(DIV_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      quo <= {quo[DIV_W-2:0], fits};
      rem <= fits ? trial[DIV_W-1:0] : rem_sh[DIV_W-1:0];
    end
  end

  assign quotient    = quo;
  assign status.busy = busy;
  assign status.done = done;

endmodule

// File: rtl/load_cell_average_tare_weigh_unit.sv
// Channel   Direction  Payload (lowest bit up)
// s_*       in         tdata: sample_code[23:0], tare_request[24]; tuser: timed_out
// m_*       out        tdata: average_code[23:0], weight_centikg[45:24],
//                      level_pct[67:46]; tuser: status[1:0]
// cfg_*     in         write: window_length, counts_per_kg, capacity_kg
//
// An item that does not close a window is counted into it in S_IDLE. The closing
// item starts the sequencer: one pass of the shared divider for the average (tare
// windows end there; it is skipped if every item timed out), then two more passes
// for weight and level.
// Reset is synchronous; the first window after reset is a tare window.
// A result waits in the output register; the block keeps taking items meanwhile
// but not while the sequencer runs, and S_OUT holds a new result until the register is free.
module load_cell_average_tare_weigh_unit #(
  parameter int MAX_WINDOW = lctw_pkg::MAX_WINDOW_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // sample_code[23:0], tare_request[24], zero fill
  input  logic [lctw_pkg::IN_DATA_W-1:0]  s_tdata,
  // timed_out
  input  logic                            s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // average_code[23:0], weight_centikg[45:24], level_pct[67:46], zero fill
  output logic [lctw_pkg::OUT_DATA_W-1:0] m_tdata,
  // status[1:0]
  output logic [1:0]                      m_tuser,
  input  logic                            cfg_we,
  input  logic [lctw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lctw_pkg::CFG_DATA_W-1:0] cfg_data
);
  import lctw_pkg::*;
  `include "load_cell_average_tare_weigh_unit_defines.svh"

  localparam int PW = $clog2(MAX_WINDOW + 1);
  localparam int SW = SAMPLE_W + $clog2(MAX_WINDOW);

  typedef enum logic [2:0] {
    S_IDLE, S_START, S_AVG, S_DIFF, S_SCALE, S_WDIV, S_LDIV, S_OUT
  } state_t;

  state_t state;

  logic [6:0]  window_length;
  logic [23:0] counts_per_kg;
  logic [7:0]  capacity_kg;

  logic signed [SW-1:0] sample_sum;
  logic [PW-1:0]        valid_count;
  logic [PW-1:0]        window_position;
  logic [SAMPLE_W-1:0]  tare_offset;
  logic                 tare_window;
  logic                 tare_pending;
  logic                 is_tare;

  logic signed [SW-1:0] win_sum;
  logic [PW-1:0]        win_count;
  logic [SAMPLE_W-1:0]  avg_reg;
  logic                 err;
  logic                 diff_neg;
  logic [31:0]          mag100;
  logic [31:0]          den_l;
  logic [OUT_W-1:0]     weight;
  logic [OUT_W-1:0]     level;

  logic [SAMPLE_W-1:0]  out_avg;
  logic [OUT_W-1:0]     out_weight;
  logic [OUT_W-1:0]     out_level;
  status_t              out_status;

  logic [31:0]          n_wide;
  logic [PW-1:0]        n_eff;
  logic [PW-1:0]        pos_inc;
  logic                 close;
  logic signed [SW-1:0] sum_add;
  logic                 pend;
  logic                 timed_out;
  logic                 accept;
  logic [SW-1:0]        win_mag;
  logic [SAMPLE_W-1:0]  avg_calc;
  logic signed [SAMPLE_W:0] diff;
  logic [SAMPLE_W:0]    diff_mag;
  logic [23:0]          cpk_eff;
  logic [7:0]           cap_eff;
  logic                 out_free;

  logic                 div_start;
  logic [DIV_W-1:0]     div_dividend;
  logic [DIV_W-1:0]     div_divisor;
  logic [DIV_W-1:0]     div_q;
  div_status_t          div_st;

  function automatic logic [OUT_W-1:0] sat22(logic [DIV_W-1:0] q, logic neg);
    logic [OUT_W-1:0] r;
    if (neg) begin
      r = (q > OUT_NEG_MAG) ? OUT_MIN_CODE : (~q[OUT_W-1:0] + 1'b1);
    end else begin
      r = (q > OUT_POS_MAG) ? OUT_MAX_CODE : q[OUT_W-1:0];
    end
    return r;
  endfunction

  always_comb begin
    timed_out = s_tuser;
    accept    = s_tvalid && s_tready;
    pend      = tare_pending | s_tdata[SAMPLE_W];
    sum_add   = sample_sum + SW'($signed(s_tdata[SAMPLE_W-1:0]));
    if (window_length == 7'd0) begin
      n_wide = 32'd1;
    end else if (32'(window_length) > 32'(MAX_WINDOW)) begin
      n_wide = 32'(MAX_WINDOW);
    end else begin
      n_wide = 32'(window_length);
    end
    n_eff    = n_wide[PW-1:0];
    pos_inc  = window_position + 1'b1;
    close    = pos_inc >= n_eff;
    win_mag  = win_sum[SW-1] ? (~win_sum + 1'b1) : win_sum;
    avg_calc = win_sum[SW-1] ? (~div_q[SAMPLE_W-1:0] + 1'b1) : div_q[SAMPLE_W-1:0];
    diff     = {avg_reg[SAMPLE_W-1], avg_reg} - {tare_offset[SAMPLE_W-1], tare_offset};
    diff_mag = diff[SAMPLE_W] ? (~diff + 1'b1) : diff;
    cpk_eff  = (counts_per_kg == 24'd0) ? 24'd1 : counts_per_kg;
    cap_eff  = (capacity_kg == 8'd0) ? 8'd1 : capacity_kg;
    out_free = !m_tvalid || m_tready;
  end

  // Operands for the shared divider; weight and level round as (2*mag + den) / (2*den).
  always_comb begin
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;
    case (state)
      S_START: begin
        div_start    = win_count != '0;
        div_dividend = DIV_W'(win_mag);
        div_divisor  = DIV_W'(win_count);
      end
      S_SCALE: begin
        div_start    = 1'b1;
        div_dividend = DIV_W'({mag100, 1'b0}) + DIV_W'(cpk_eff);
        div_divisor  = DIV_W'({cpk_eff, 1'b0});
      end
      S_WDIV: begin
        div_start    = div_st.done;
        div_dividend = DIV_W'({mag100, 1'b0}) + DIV_W'(den_l);
        div_divisor  = DIV_W'({den_l, 1'b0});
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  lctw_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_q),
    .status   (div_st)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      window_length   <= WINDOW_LENGTH_RESET;
      counts_per_kg   <= COUNTS_PER_KG_RESET;
      capacity_kg     <= CAPACITY_KG_RESET;
      sample_sum      <= '0;
      valid_count     <= '0;
      window_position <= '0;
      tare_offset     <= '0;
      tare_window     <= 1'b1;
      tare_pending    <= 1'b0;
      m_tvalid        <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_WINDOW_LENGTH: window_length <= cfg_data[6:0];
          CFG_COUNTS_PER_KG: counts_per_kg <= cfg_data[23:0];
          CFG_CAPACITY_KG:   capacity_kg   <= cfg_data[7:0];
          default: ;
        endcase
      end

      // In S_OUT the output register is reloaded in the same cycle instead.
      if (m_tvalid && m_tready && state != S_OUT) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (close) begin
              win_sum         <= timed_out ? sample_sum : sum_add;
              win_count       <= timed_out ? valid_count : valid_count + 1'b1;
              sample_sum      <= '0;
              valid_count     <= '0;
              window_position <= '0;
              is_tare         <= tare_window;
              tare_window     <= pend;
              tare_pending    <= 1'b0;
              state           <= S_START;
            end else begin
              if (!timed_out) begin
                sample_sum  <= sum_add;
                valid_count <= valid_count + 1'b1;
              end
              window_position <= pos_inc;
              tare_pending    <= pend;
            end
          end
        end
        S_START: begin
          err <= win_count == '0;
          if (win_count == '0) begin
            if (is_tare) begin
              tare_offset <= '0;
              state       <= S_IDLE;
            end else begin
              avg_reg <= '0;
              state   <= S_DIFF;
            end
          end else begin
            state <= S_AVG;
          end
        end
        S_AVG: begin
          if (div_st.done) begin
            if (is_tare) begin
              tare_offset <= avg_calc;
              state       <= S_IDLE;
            end else begin
              avg_reg <= avg_calc;
              state   <= S_DIFF;
            end
          end
        end
        S_DIFF: begin
          diff_neg <= diff[SAMPLE_W];
          mag100   <= 32'(diff_mag) * 32'd100;
          den_l    <= 32'(cpk_eff) * 32'(cap_eff);
          state    <= S_SCALE;
        end
        S_SCALE: begin
          state <= S_WDIV;
        end
        S_WDIV: begin
          if (div_st.done) begin
            weight <= sat22(div_q, diff_neg);
            state  <= S_LDIV;
          end
        end
        S_LDIV: begin
          if (div_st.done) begin
            level <= sat22(div_q, diff_neg);
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_avg    <= avg_reg;
            out_weight <= weight;
            out_level  <= level;
            if (err) begin
              out_status <= STATUS_NO_SAMPLE;
            end else if (avg_reg == FULL_SCALE_POS || avg_reg == FULL_SCALE_NEG) begin
              out_status <= STATUS_FULL_SCALE;
            end else begin
              out_status <= STATUS_OK;
            end
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign s_tready = state == S_IDLE;
  assign m_tdata  = {4'b0, out_level, out_weight, out_avg};
  assign m_tuser  = out_status;

  `LCTW_ASSERT(a_done_in_wait_state, div_st.done |-> (state == S_AVG || state == S_WDIV || state == S_LDIV), "divider finished outside a wait state")
  `LCTW_ASSERT(a_no_accept_while_busy, accept |-> !div_st.busy, "item accepted while the divider runs")
  `LCTW_ASSERT_ALWAYS(a_count_within_position, rst || (valid_count <= window_position), "valid count exceeds window position")
  `LCTW_ASSERT(a_close_starts_sequence, (accept && close) |=> (state == S_START && window_position == '0), "window close did not start the sequencer")

endmodule

// File: sim/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lctw_pkg::*;

  localparam int RANDOM_ITEMS  = 900;
  localparam int SETTLE_CYCLES = 160;
  localparam int TAIL_CYCLES   = 200;
  localparam int CYCLE_LIMIT   = 1000000;

  typedef struct packed {
    logic [23:0] average;
    logic [21:0] weight;
    logic [21:0] level;
    status_t     status;
  } weigh_result_t;

  typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

  typedef struct packed {
    row_kind_t     kind;
    logic [23:0]   code;
    logic          lost;
    logic          zero_req;
    logic [1:0]    index;
    logic [23:0]   value;
    logic          typed;
    weigh_result_t want;
  } plan_row_t;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic                  s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [1:0]            m_tuser;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Mirror of the registers and the window state.
  int      win_len;
  longint  counts_kg;
  longint  cap_kg;
  longint  acc_sum;
  longint  acc_valid;
  int      acc_pos;
  longint  zero_offset;
  bit      zero_window;
  bit      zero_pending;

  weigh_result_t weigh_q[$];
  plan_row_t     plan[$];
  int            fault_count;
  int            cycle_count;
  bit            steady;

  load_cell_average_tare_weigh_unit u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    if (fault_count < 40) $display("mismatch at cycle %0d: %s", cycle_count, msg);
    fault_count++;
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (steady || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Rounds num/den half away from zero and clamps to the 22-bit output range.
  function automatic logic [21:0] scaled_round(input longint num, input longint den);
    longint mag;
    longint q;
    mag = (num < 0) ? -num : num;
    q = (mag * 2 + den) / (den * 2);
    if (num < 0) return (q > longint'(OUT_NEG_MAG)) ? OUT_MIN_CODE : 22'(-q);
    return (q > longint'(OUT_POS_MAG)) ? OUT_MAX_CODE : 22'(q);
  endfunction

  function automatic bit weigh_step(input logic [23:0] code, input bit lost, input bit zero_req,
                                    output weigh_result_t res);
    logic signed [23:0] sample;
    int     n;
    longint avg;
    longint diff;
    longint cpk;
    longint cap;
    bit     none;
    sample = code;
    res = '0;
    if (zero_req) zero_pending = 1'b1;
    if (!lost) begin
      acc_sum = acc_sum + sample;
      acc_valid++;
    end
    acc_pos++;
    n = (win_len == 0) ? 1 : ((win_len > MAX_WINDOW_DEFAULT) ? MAX_WINDOW_DEFAULT : win_len);
    if (acc_pos < n) return 1'b0;
    none = (acc_valid == 0);
    avg = none ? 0 : acc_sum / acc_valid;
    acc_sum = 0;
    acc_valid = 0;
    acc_pos = 0;
    if (zero_window) begin
      zero_offset = avg;
      zero_window = zero_pending;
      zero_pending = 1'b0;
      return 1'b0;
    end
    zero_window = zero_pending;
    zero_pending = 1'b0;
    cpk = (counts_kg == 0) ? 1 : counts_kg;
    cap = (cap_kg == 0) ? 1 : cap_kg;
    diff = avg - zero_offset;
    res.average = avg[23:0];
    res.weight = scaled_round(diff * 100, cpk);
    res.level = scaled_round(diff * 100, cpk * cap);
    if (none) res.status = STATUS_NO_SAMPLE;
    else if (avg == 8388607 || avg == -8388608) res.status = STATUS_FULL_SCALE;
    else res.status = STATUS_OK;
    return 1'b1;
  endfunction

  task automatic add_sample(input logic [23:0] code, input bit lost, input bit zero_req);
    plan_row_t row;
    row = '0;
    row.kind = ROW_SAMPLE;
    row.code = code;
    row.lost = lost;
    row.zero_req = zero_req;
    plan.push_back(row);
  endtask

  task automatic add_checked(input logic [23:0] code, input bit lost, input bit zero_req,
                             input int avg, input int weight, input int level,
                             input status_t st);
    plan_row_t row;
    row = '0;
    row.kind = ROW_SAMPLE;
    row.code = code;
    row.lost = lost;
    row.zero_req = zero_req;
    row.typed = 1'b1;
    row.want.average = 24'(avg);
    row.want.weight = 22'(weight);
    row.want.level = 22'(level);
    row.want.status = st;
    plan.push_back(row);
  endtask

  task automatic add_write(input logic [1:0] index, input logic [23:0] value);
    plan_row_t row;
    row = '0;
    row.kind = ROW_WRITE;
    row.index = index;
    row.value = value;
    plan.push_back(row);
  endtask

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic send_sample(input logic [23:0] code, input bit lost, input bit zero_req,
                             input bit typed, input weigh_result_t typed_want);
    weigh_result_t res;
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= IN_DATA_W'({zero_req, code});
    s_tuser <= lost;
    do @(posedge clk); while (!s_tready);
    if (weigh_step(code, lost, zero_req, res) || typed) weigh_q.push_back(typed ? typed_want : res);
    @(negedge clk);
  endtask

  // Lets every expected result drain, then gives a window that closed without a
  // result time to finish before the registers change.
  task automatic settle();
    s_tvalid <= 1'b0;
    while (weigh_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] index, input logic [23:0] value);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    case (index)
      CFG_WINDOW_LENGTH: win_len = value[6:0];
      CFG_COUNTS_PER_KG: counts_kg = value;
      CFG_CAPACITY_KG:   cap_kg = value[7:0];
      default: ;
    endcase
  endtask

  initial begin
    m_tready = 1'b0;
    @(negedge clk);
    forever begin
      int stall;
      m_tready <= 1'b1;
      repeat ($urandom_range(1, ($urandom_range(3) == 0) ? 60 : 6)) @(negedge clk);
      stall = pick_gap();
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin : watch_results
    weigh_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (weigh_q.size() == 0) begin
        report_mismatch("result transaction with nothing expected");
      end else begin
        want = weigh_q.pop_front();
        if (m_tdata[23:0] !== want.average)
          report_mismatch($sformatf("average %0d, expected %0d",
                                    $signed(m_tdata[23:0]), $signed(want.average)));
        if (m_tdata[45:24] !== want.weight)
          report_mismatch($sformatf("weight %0d, expected %0d",
                                    $signed(m_tdata[45:24]), $signed(want.weight)));
        if (m_tdata[67:46] !== want.level)
          report_mismatch($sformatf("level %0d, expected %0d",
                                    $signed(m_tdata[67:46]), $signed(want.level)));
        if (m_tuser !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d", m_tuser, want.status));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  initial begin
    int sent;
    int phase_len;
    int r;
    int spread;
    int lost_pct;
    logic [23:0] base;
    logic [23:0] code;
    weigh_result_t none_typed;

    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    cycle_count = 0;
    fault_count = 0;
    steady = 1'b0;
    none_typed = '0;
    win_len = WINDOW_LENGTH_RESET;
    counts_kg = COUNTS_PER_KG_RESET;
    cap_kg = CAPACITY_KG_RESET;
    acc_sum = 0;
    acc_valid = 0;
    acc_pos = 0;
    zero_offset = 0;
    zero_window = 1'b1;
    zero_pending = 1'b0;

    // The boot tare window comes first; a one-item window keeps the rest readable.
    add_write(CFG_WINDOW_LENGTH, 24'd1);
    add_sample(24'h000000, 1'b0, 1'b0);
    add_checked(FULL_SCALE_POS, 1'b0, 1'b0, 8388607, 28533, 2195, STATUS_FULL_SCALE);
    add_checked(FULL_SCALE_NEG, 1'b0, 1'b0, -8388608, -28533, -2195, STATUS_FULL_SCALE);
    add_checked(24'h123456, 1'b1, 1'b0, 0, 0, 0, STATUS_NO_SAMPLE);
    // Tare request on the closing item, then another during the tare window.
    add_checked(24'h000000, 1'b0, 1'b1, 0, 0, 0, STATUS_OK);
    add_sample(24'h000400, 1'b0, 1'b1);
    add_sample(24'hABCDEF, 1'b1, 1'b0);
    add_sample(24'd29400, 1'b0, 1'b0);
    add_write(CFG_COUNTS_PER_KG, 24'd0);
    add_sample(24'hFFFFFF, 1'b0, 1'b0);
    add_write(CFG_CAPACITY_KG, 24'd0);
    add_sample(24'h000005, 1'b0, 1'b0);
    add_write(CFG_COUNTS_PER_KG, 24'hFFFFFF);
    add_write(CFG_CAPACITY_KG, 24'd255);
    add_sample(FULL_SCALE_POS, 1'b0, 1'b0);
    add_sample(FULL_SCALE_NEG, 1'b0, 1'b0);
    add_write(CFG_COUNTS_PER_KG, 24'd1);
    add_write(CFG_CAPACITY_KG, 24'd1);
    add_checked(FULL_SCALE_POS, 1'b0, 1'b0, 8388607, 2097151, 2097151, STATUS_FULL_SCALE);
    add_checked(FULL_SCALE_NEG, 1'b0, 1'b0, -8388608, -2097152, -2097152, STATUS_FULL_SCALE);
    add_sample(24'h000200, 1'b0, 1'b0);
    // Exact halves round away from zero.
    add_write(CFG_COUNTS_PER_KG, 24'd200);
    add_sample(24'h000001, 1'b0, 1'b0);
    add_sample(24'hFFFFFF, 1'b0, 1'b0);
    add_write(CFG_WINDOW_LENGTH, 24'd0);
    add_sample(24'h0003E8, 1'b0, 1'b0);
    // Shorten the window after two items; -2/3 truncates to zero.
    add_write(CFG_WINDOW_LENGTH, 24'd4);
    add_sample(24'hFFFFFF, 1'b0, 1'b0);
    add_sample(24'hFFFFFF, 1'b0, 1'b0);
    add_write(CFG_WINDOW_LENGTH, 24'd2);
    add_sample(24'h000000, 1'b0, 1'b0);

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int i = 0; i < plan.size(); i++) begin
      if (plan[i].kind == ROW_WRITE) begin
        settle();
        write_reg(plan[i].index, plan[i].value);
      end else begin
        send_sample(plan[i].code, plan[i].lost, plan[i].zero_req, plan[i].typed, plan[i].want);
      end
    end

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      settle();
      r = $urandom_range(99);
      if (r < 60) write_reg(CFG_WINDOW_LENGTH, 24'($urandom_range(1, 8)));
      else if (r < 80) write_reg(CFG_WINDOW_LENGTH, 24'($urandom_range(9, 20)));
      else if (r < 90) write_reg(CFG_WINDOW_LENGTH, 24'($urandom_range(0, 1)));
      else write_reg(CFG_WINDOW_LENGTH, 24'($urandom_range(64, 127)));
      r = $urandom_range(99);
      if (r < 40) write_reg(CFG_COUNTS_PER_KG, 24'($urandom_range(1000, 100000)));
      else if (r < 60) write_reg(CFG_COUNTS_PER_KG, COUNTS_PER_KG_RESET);
      else if (r < 80) write_reg(CFG_COUNTS_PER_KG, 24'($urandom_range(1000, 16777215)));
      else if (r < 90) write_reg(CFG_COUNTS_PER_KG, 24'($urandom_range(0, 999)));
      else write_reg(CFG_COUNTS_PER_KG, 24'hFFFFFF);
      r = $urandom_range(99);
      if (r < 50) write_reg(CFG_CAPACITY_KG, 24'($urandom_range(1, 30)));
      else if (r < 80) write_reg(CFG_CAPACITY_KG, 24'($urandom_range(1, 255)));
      else if (r < 90) write_reg(CFG_CAPACITY_KG, 24'd0);
      else write_reg(CFG_CAPACITY_KG, 24'd255);

      steady = ($urandom_range(3) == 0);
      base = ($urandom_range(1) == 0) ? 24'($urandom_range(0, 400000) - 200000) : 24'($urandom);
      spread = $urandom_range(0, 5000);
      lost_pct = ($urandom_range(9) == 0) ? 90 : $urandom_range(0, 15);
      phase_len = (win_len >= MAX_WINDOW_DEFAULT) ? 150 : $urandom_range(20, 80);

      for (int k = 0; k < phase_len; k++) begin
        r = $urandom_range(99);
        if (r < 4) code = $urandom_range(1) ? FULL_SCALE_POS : FULL_SCALE_NEG;
        else if (r < 14) code = 24'($urandom);
        else code = base + 24'($urandom_range(0, 2 * spread) - spread);
        send_sample(code, ($urandom_range(99) < lost_pct), ($urandom_range(99) < 3),
                    1'b0, none_typed);
        sent++;
      end
    end

    s_tvalid <= 1'b0;
    while (weigh_q.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (fault_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/lctw_pkg.sv
rtl/lctw_div.sv
rtl/load_cell_average_tare_weigh_unit.sv
sim/tb.sv
